@@ rtl/lbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbc_pkg - shared definitions of the lamp button controller
// Field widths, register indexes, reset values and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lbc_pkg;

  // Default storage depth
  localparam int MAX_LAMPS_DEF = 16;

  // Field widths
  localparam int NOW_W      = 32;
  localparam int BTN_W      = 16;
  localparam int LIDX_W     = 4;
  localparam int STATE_W    = 16;
  localparam int COUNT_W    = 5;
  localparam int NOISE_W    = 10;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAMP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MS    = 2'd2;

  // Register reset values
  localparam logic [COUNT_W-1:0] LAMP_COUNT_RST = 5'd12;
  localparam logic [NOISE_W-1:0] NOISE_MS_RST   = 10'd50;
  localparam logic [STEP_W-1:0]  STEP_MS_RST    = 16'd500;

  // Item kinds
  localparam logic KIND_SCAN   = 1'b0;
  localparam logic KIND_REMOTE = 1'b1;

  // Controller to datapath commands, at most one high per cycle
  typedef struct packed {
    logic capture;   // take the accepted transaction, apply a remote set
    logic load;      // edge handling of the current lamp
    logic search;    // one bit of the interval quotient
    logic finish;    // lamp cycle step of the current lamp, advance
    logic publish;   // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_skip;    // incoming transaction walks no lamp
    logic pressed;      // current lamp's button is pressed
    logic search_last;  // last quotient bit in progress
    logic lamp_last;    // current lamp is the last one in use
    logic out_free;     // output register can take a result
  } sts_t;

endpackage

@@ rtl/lamp_button_controller.sv @@
// ----------------------------------------------------------------------------
// lamp_button_controller - push-button lamp control for up to MAX_LAMPS lamps
// Short press toggles a lamp, a held button steps through the lamps, a remote
// item sets one lamp. One result per item: lamp states and a change mask.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_tvalid/in_tready   tuser kind, tdata time/buttons/set
//  out_     output     out_tvalid/out_tready tdata lamp states, change mask
//  cfg_     input      cfg_we                cfg_index, cfg_wdata
//
//  Per item: capture, then for each lamp in use a load step, for a pressed
//  lamp a search over S = clog2(MAX_LAMPS + 2) quotient bits (5 at 16 lamps),
//  and a finish step, then the publish; a remote item skips the lamp walk.
//  Reset is synchronous and clears all lamps, buttons, timers and steps.
//  A new item is taken while the last result waits; the walk then holds in
//  its last step until the output register frees up.
// ----------------------------------------------------------------------------
module lamp_button_controller #(
  parameter int MAX_LAMPS = lbc_pkg::MAX_LAMPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg_wdata: register value, low bits used
  input  logic                            cfg_we,
  input  logic [lbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata: now_ms[31:0], buttons[47:32], lamp_index[51:48], lamp_value[52]
  input  logic [lbc_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: kind[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: lamp_states[15:0], changed[31:16]
  output logic [lbc_pkg::OUT_DATA_W-1:0]  out_tdata
);

  lbc_pkg::cmd_t cmd;
  lbc_pkg::sts_t sts;

  logic [lbc_pkg::STATE_W-1:0] states;
  logic [lbc_pkg::STATE_W-1:0] changed;

  lbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  lbc_datapath #(
    .MAX_LAMPS (MAX_LAMPS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_kind     (in_tuser),
    .in_now      (in_tdata[31:0]),
    .in_buttons  (in_tdata[47:32]),
    .in_index    (in_tdata[51:48]),
    .in_value    (in_tdata[52]),
    .out_ready   (out_tready),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_states  (states),
    .out_changed (changed)
  );

  assign out_tdata = {changed, states};

endmodule

@@ rtl/lbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbc_ctrl - sequencer of the lamp button controller
// Walks the lamps in turn: edge handling, a quotient search for a pressed lamp
// and the lamp cycle step, then hands the result to the output register.
// ----------------------------------------------------------------------------
module lbc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  lbc_pkg::sts_t sts,
  output lbc_pkg::cmd_t cmd,
  output logic          in_ready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.walk_skip ? S_OUT : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = sts.pressed ? S_SEARCH : S_FINISH;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.search_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = sts.lamp_last ? S_OUT : S_LOAD;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/lbc_datapath.sv @@
// ----------------------------------------------------------------------------
// lbc_datapath - lamp state, per-button timing and the interval search
// Holds the registers, the per-lamp press records and the output register.
// The held-button step count comes from a bit-serial quotient search that
// uses one small multiply and compare per cycle.
// ----------------------------------------------------------------------------
module lbc_datapath #(
  parameter int MAX_LAMPS = lbc_pkg::MAX_LAMPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_kind,
  input  logic [lbc_pkg::NOW_W-1:0]        in_now,
  input  logic [lbc_pkg::BTN_W-1:0]        in_buttons,
  input  logic [lbc_pkg::LIDX_W-1:0]       in_index,
  input  logic                             in_value,
  input  logic                             out_ready,
  input  lbc_pkg::cmd_t                    cmd,
  output lbc_pkg::sts_t                    sts,
  output logic                             out_valid,
  output logic [lbc_pkg::STATE_W-1:0]      out_states,
  output logic [lbc_pkg::STATE_W-1:0]      out_changed
);

  localparam int CNT_W = $clog2(MAX_LAMPS + 1);
  localparam int IDX_W = (MAX_LAMPS > 1) ? $clog2(MAX_LAMPS) : 1;
  localparam int SW    = $clog2(MAX_LAMPS + 2);
  localparam int BIT_W = $clog2(SW);
  localparam int CMP_W = 7;
  localparam int PW    = SW + lbc_pkg::STEP_W;
  localparam int NW    = lbc_pkg::NOW_W;
  localparam logic [MAX_LAMPS-1:0] ONE = MAX_LAMPS'(1);

  // Configuration
  logic [lbc_pkg::COUNT_W-1:0] lamp_count_r;
  logic [lbc_pkg::NOISE_W-1:0] noise_r;
  logic [lbc_pkg::STEP_W-1:0]  step_r;

  // Captured transaction
  logic                      kind_r;
  logic [NW-1:0]             now_r;
  logic [lbc_pkg::BTN_W-1:0] buttons_r;
  logic [MAX_LAMPS-1:0]      before_r;

  // Lamp and button records
  logic [MAX_LAMPS-1:0] lamp_r;
  logic [MAX_LAMPS-1:0] last_r;
  logic [NW-1:0]        ps_r [MAX_LAMPS];
  logic [MAX_LAMPS-1:0] csv_r;
  logic [CNT_W-1:0]     csval_r [MAX_LAMPS];

  // Walk and search
  logic [IDX_W-1:0] idx_r;
  logic             pressed_r;
  logic [NW-1:0]    elapsed_r;
  logic [SW-1:0]    acc_r;
  logic [BIT_W-1:0] bit_r;

  // Output register
  logic                        out_valid_r;
  logic [lbc_pkg::STATE_W-1:0] out_states_r;
  logic [lbc_pkg::STATE_W-1:0] out_changed_r;

  logic [CNT_W-1:0]            count_act;
  logic                        remote_hit;
  logic [MAX_LAMPS-1:0]        btn_vec;
  logic [lbc_pkg::STATE_W-1:0] lamp16;
  logic [lbc_pkg::STATE_W-1:0] before16;
  logic                        pressed_cur;
  logic [NW-1:0]               held;
  logic                        edge_cur;
  logic                        short_rel;
  logic [MAX_LAMPS-1:0]        onehot_i;
  logic [lbc_pkg::STEP_W-1:0]  div;
  logic [SW-1:0]               cand;
  logic [SW-1:0]               limit;
  logic [PW-1:0]               prod;
  logic                        fit;
  logic [CNT_W-1:0]            pos;
  logic                        differs;
  logic [MAX_LAMPS-1:0]        step_mask;

  // Lamps in use, clamped to the storage depth
  assign count_act = (CMP_W'(lamp_count_r) > CMP_W'(MAX_LAMPS)) ? CNT_W'(MAX_LAMPS)
                                                                 : CNT_W'(lamp_count_r);
  assign remote_hit = CMP_W'(in_index) < CMP_W'(count_act);

  // Map the button field onto the lamp records and the lamps onto the result
  for (genvar j = 0; j < MAX_LAMPS; j++) begin : g_btn
    if (j < lbc_pkg::BTN_W) begin : g_in
      assign btn_vec[j] = buttons_r[j];
    end else begin : g_zero
      assign btn_vec[j] = 1'b0;
    end
  end
  for (genvar j = 0; j < lbc_pkg::STATE_W; j++) begin : g_out
    if (j < MAX_LAMPS) begin : g_in
      assign lamp16[j]   = lamp_r[j];
      assign before16[j] = before_r[j];
    end else begin : g_zero
      assign lamp16[j]   = 1'b0;
      assign before16[j] = 1'b0;
    end
  end

  // Edge handling of the current lamp
  assign pressed_cur = btn_vec[idx_r];
  assign held        = now_r - ps_r[idx_r];
  assign edge_cur    = pressed_cur != last_r[idx_r];
  assign short_rel   = !pressed_cur && (held > NW'(noise_r)) && (held < NW'(step_r));
  assign onehot_i    = ONE << idx_r;

  // One quotient bit: keep it when cand is within limit and cand steps fit in the elapsed time
  assign div   = (step_r == '0) ? lbc_pkg::STEP_W'(1) : step_r;
  assign cand  = acc_r | (SW'(1) << bit_r);
  assign limit = SW'(count_act) + SW'(1);
  assign prod  = PW'(cand) * PW'(div);
  assign fit   = (cand <= limit) && (NW'(prod) <= elapsed_r);

  // Lamp cycle step: restore the previous pick, invert the new one
  assign pos     = CNT_W'(acc_r - SW'(1));
  assign differs = !csv_r[idx_r] || (csval_r[idx_r] != pos);
  always_comb begin
    step_mask = '0;
    if (csv_r[idx_r] && (csval_r[idx_r] < count_act)) begin
      step_mask = step_mask ^ (ONE << csval_r[idx_r]);
    end
    if (pos < count_act) begin
      step_mask = step_mask ^ (ONE << pos);
    end
  end

  // Status
  assign sts.walk_skip   = in_kind || (count_act == '0);
  assign sts.pressed     = pressed_cur;
  assign sts.search_last = (bit_r == '0);
  assign sts.lamp_last   = (CNT_W'(idx_r) + CNT_W'(1)) == count_act;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_states  = out_states_r;
  assign out_changed = out_changed_r;

  // Control and record registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_count_r <= lbc_pkg::LAMP_COUNT_RST;
      noise_r      <= lbc_pkg::NOISE_MS_RST;
      step_r       <= lbc_pkg::STEP_MS_RST;
      lamp_r       <= '0;
      last_r       <= '0;
      csv_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < MAX_LAMPS; k++) begin
        ps_r[k] <= '0;
      end
    end else begin
      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          lbc_pkg::REG_LAMP_COUNT: lamp_count_r <= cfg_wdata[lbc_pkg::COUNT_W-1:0];
          lbc_pkg::REG_NOISE_MS:   noise_r      <= cfg_wdata[lbc_pkg::NOISE_W-1:0];
          lbc_pkg::REG_STEP_MS:    step_r       <= cfg_wdata[lbc_pkg::STEP_W-1:0];
          default: begin
          end
        endcase
      end

      // Hold the result until the transaction completes
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Remote set of one lamp
      if (cmd.capture && in_kind && remote_hit) begin
        if (in_value) begin
          lamp_r <= lamp_r | (ONE << in_index);
        end else begin
          lamp_r <= lamp_r & ~(ONE << in_index);
        end
      end

      // Button edge: short-release toggle, restart the press timer
      if (cmd.load && edge_cur) begin
        last_r[idx_r] <= pressed_cur;
        ps_r[idx_r]   <= pressed_cur ? now_r : '0;
        if (short_rel) begin
          lamp_r <= lamp_r ^ onehot_i;
        end
      end

      // Held button: apply the step reached
      if (cmd.finish && pressed_r) begin
        if (acc_r == '0) begin
          csv_r[idx_r] <= 1'b0;
        end else if (differs) begin
          lamp_r       <= lamp_r ^ step_mask;
          csv_r[idx_r] <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r    <= in_kind;
      now_r     <= in_now;
      buttons_r <= in_buttons;
      before_r  <= lamp_r;
      idx_r     <= '0;
    end
    if (cmd.load) begin
      pressed_r <= pressed_cur;
      elapsed_r <= edge_cur ? '0 : held;
      acc_r     <= '0;
      bit_r     <= BIT_W'(SW - 1);
    end
    if (cmd.search) begin
      if (fit) begin
        acc_r <= cand;
      end
      bit_r <= bit_r - BIT_W'(1);
    end
    if (cmd.finish) begin
      if (pressed_r && (acc_r != '0) && differs) begin
        csval_r[idx_r] <= pos;
      end
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.publish) begin
      out_states_r  <= lamp16;
      // Remote items carry no lamp walk; kind only tags the capture
      out_changed_r <= (kind_r == lbc_pkg::KIND_REMOTE) ? (lamp16 ^ before16)
                                                         : (lamp16 ^ before16);
    end
  end

endmodule

@@ rtl/lbc_checker.sv @@
// ----------------------------------------------------------------------------
// lbc_checker - port-level checks of the lamp button controller
// Watches the top-level ports and flags handshake or sequencing slips.
// ----------------------------------------------------------------------------
module lbc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [lbc_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lbc_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk)
    rst_n && out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk)
    rst_n && in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("stalled input dropped or changed");

  // Take one transaction at a time
  a_one_item: assert property (@(posedge clk)
    rst_n && in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is at work");

  // Come out of reset idle with no result
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the controller");

endmodule

bind lamp_button_controller lbc_checker u_lbc_checker (.*);
